@@ sv/gha_pkg.sv @@
// Shared constants, codes and control types of the generational handle allocator.
package gha_pkg;

    localparam int INDEX_BITS = 10;
    localparam int GEN_BITS   = 8;
    localparam int CNT_BITS   = INDEX_BITS + 1;
    localparam int SLOTS      = 1 << INDEX_BITS;

    localparam logic [CNT_BITS-1:0] SLOTS_CNT = {1'b1, {INDEX_BITS{1'b0}}};

    localparam int FUNC_BITS   = 2;
    localparam int STATUS_BITS = 2;

    // Input transfer layout, lowest bit first: func, handle_index, handle_generation.
    localparam int IN_FUNC_LSB  = 0;
    localparam int IN_IDX_LSB   = IN_FUNC_LSB + FUNC_BITS;
    localparam int IN_GEN_LSB   = IN_IDX_LSB + INDEX_BITS;
    localparam int IN_FIELDS_W  = IN_GEN_LSB + GEN_BITS;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

    // Output transfer layout, lowest bit first: new_index, new_generation, is_alive, status.
    localparam int OUT_FIELDS_W = INDEX_BITS + GEN_BITS + 1 + STATUS_BITS;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [FUNC_BITS-1:0] FN_CREATE  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FN_QUERY   = 2'd1;
    localparam logic [FUNC_BITS-1:0] FN_DESTROY = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_DEAD = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic capture;   // latch the request and start both memory reads
        logic pop_read;  // popped slot is on the stack read port; read its generation
        logic commit;    // write memories and counters, load the output register
    } cmd_t;

    typedef struct packed {
        logic pop_path;  // request at the input is a create served from the free stack
        logic out_free;  // output register can take a result this cycle
    } stat_t;

endpackage

@@ sv/gha_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/gha_ctrl.sv @@
// Controller state machine that sequences each request through the datapath.
module gha_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  gha_pkg::stat_t stat,
    output gha_pkg::cmd_t  cmd
);
    import gha_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = stat.pop_path ? S_POP : S_EXEC;
                end
            end
            S_POP:
            begin
                cmd.pop_read = 1'b1;
                state_next   = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The execute step always follows the pop step directly.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |=> state_reg == S_EXEC)
        else $error("pop step not followed by execute step");

    // After a commit the block is ready for the next request.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> state_reg == S_IDLE)
        else $error("commit did not return to idle");

    // A new request is only captured when nothing is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !$past(cmd.pop_read) && state_reg == S_IDLE)
        else $error("request captured while another was in flight");

endmodule

@@ sv/gha_dp.sv @@
// Datapath: request registers, generation and free-stack memories, counters, output register.
module gha_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gha_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gha_pkg::OUT_DATA_W-1:0] m_tdata,
    input  gha_pkg::cmd_t                  cmd,
    output gha_pkg::stat_t                 stat
);
    import gha_pkg::*;

    logic [FUNC_BITS-1:0]  in_func;
    logic [INDEX_BITS-1:0] in_idx;
    logic [GEN_BITS-1:0]   in_gen;

    logic [FUNC_BITS-1:0]  func_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [GEN_BITS-1:0]   gen_reg;
    logic                  popped_reg;
    logic [INDEX_BITS-1:0] slot_reg;

    logic [CNT_BITS-1:0]   free_count_reg;
    logic [CNT_BITS-1:0]   free_count_next;
    logic [CNT_BITS-1:0]   slots_used_reg;
    logic [CNT_BITS-1:0]   slots_used_next;
    logic [CNT_BITS-1:0]   free_count_dec;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                  gen_we;
    logic [INDEX_BITS-1:0] gen_waddr;
    logic [GEN_BITS-1:0]   gen_wdata;
    logic                  gen_re;
    logic [INDEX_BITS-1:0] gen_raddr;
    logic [GEN_BITS-1:0]   gen_rdata;

    logic                  stk_we;
    logic [INDEX_BITS-1:0] stk_rdata;

    logic                  alive;
    logic [INDEX_BITS-1:0] res_idx;
    logic [GEN_BITS-1:0]   res_gen;
    logic                  res_alive;
    logic [STATUS_BITS-1:0] res_status;

    assign in_func = s_tdata[IN_FUNC_LSB +: FUNC_BITS];
    assign in_idx  = s_tdata[IN_IDX_LSB +: INDEX_BITS];
    assign in_gen  = s_tdata[IN_GEN_LSB +: GEN_BITS];

    assign free_count_dec = free_count_reg - CNT_BITS'(1);

    assign stat.pop_path = (in_func == FN_CREATE) && (free_count_reg != '0);
    assign stat.out_free = !out_valid_reg || m_tready;

    // Generation read address: the handle's slot, or the slot just popped from the stack.
    assign gen_re    = cmd.capture || cmd.pop_read;
    assign gen_raddr = cmd.pop_read ? stk_rdata : in_idx;

    // Slots at or above the high-water mark were never handed out.
    assign alive = ({1'b0, idx_reg} < slots_used_reg) && (gen_rdata == gen_reg);

    always_comb
    begin
        res_idx         = '0;
        res_gen         = '0;
        res_alive       = 1'b0;
        res_status      = ST_OK;
        gen_we          = 1'b0;
        gen_waddr       = idx_reg;
        gen_wdata       = gen_rdata + GEN_BITS'(1);
        stk_we          = 1'b0;
        free_count_next = free_count_reg;
        slots_used_next = slots_used_reg;
        case (func_reg)
            FN_CREATE:
            begin
                if (popped_reg)
                begin
                    res_idx         = slot_reg;
                    res_gen         = gen_rdata;
                    free_count_next = free_count_dec;
                end
                else if (slots_used_reg < SLOTS_CNT)
                begin
                    res_idx         = slots_used_reg[INDEX_BITS-1:0];
                    gen_we          = 1'b1;
                    gen_waddr       = slots_used_reg[INDEX_BITS-1:0];
                    gen_wdata       = '0;
                    slots_used_next = slots_used_reg + CNT_BITS'(1);
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            FN_QUERY:
            begin
                res_alive = alive;
            end
            FN_DESTROY:
            begin
                if (!alive)
                begin
                    res_status = ST_DEAD;
                end
                else
                begin
                    gen_we = 1'b1;
                    if (free_count_reg < SLOTS_CNT)
                    begin
                        stk_we          = 1'b1;
                        free_count_next = free_count_reg + CNT_BITS'(1);
                    end
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    gha_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (SLOTS)
    ) u_gen_ram (
        .clk   (clk),
        .we    (cmd.commit && gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (gen_re),
        .raddr (gen_raddr),
        .rdata (gen_rdata)
    );

    gha_ram #(
        .WIDTH (INDEX_BITS),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (cmd.commit && stk_we),
        .waddr (free_count_reg[INDEX_BITS-1:0]),
        .wdata (idx_reg),
        .re    (cmd.capture),
        .raddr (free_count_dec[INDEX_BITS-1:0]),
        .rdata (stk_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= in_func;
            idx_reg    <= in_idx;
            gen_reg    <= in_gen;
            popped_reg <= stat.pop_path;
        end
        if (cmd.pop_read)
        begin
            slot_reg <= stk_rdata;
        end
        if (cmd.commit)
        begin
            out_data_reg <= OUT_DATA_W'({res_status, res_alive, res_gen, res_idx});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg <= '0;
            slots_used_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                free_count_reg <= free_count_next;
                slots_used_reg <= slots_used_next;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A waiting result is never overwritten by the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && out_valid_reg |-> m_tready)
        else $error("result committed over an untaken result");

    assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= SLOTS_CNT)
        else $error("free stack count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        slots_used_reg <= SLOTS_CNT)
        else $error("slot high-water mark beyond capacity");

endmodule

@@ sv/generational_handle_allocator.sv @@
// Query, destroy and fresh-slot create pass through capture, then the execute step loads the output register.
// A create served from the free stack adds a pop step: stack read at capture, then generation read.
// A new request is taken only once the last one has committed; execute waits for a free output register.
// The input is taken again while a finished result still waits in the output register.
// Reset clears the free-stack count and the slot high-water mark; no memory sweep is needed,
// since slots at or above the high-water mark count as never used and are zeroed on first create.
module generational_handle_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request transfer.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Lowest bit up: func[1:0], handle_index[11:2], handle_generation[19:12], zero pad.
    input  logic [gha_pkg::IN_DATA_W-1:0]  s_tdata,
    // Result transfer.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Lowest bit up: new_index[9:0], new_generation[17:10], is_alive[18], status[20:19], pad.
    output logic [gha_pkg::OUT_DATA_W-1:0] m_tdata
);
    import gha_pkg::*;

    // The controller sequences each request; the datapath holds the memories,
    // the counters and the output register, and reports back only two status bits.
    cmd_t  cmd;
    stat_t stat;

    gha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gha_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

@@ verif/gha_checker.sv @@
// Checker for the generational handle allocator: predicts each result and compares it.
module gha_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [gha_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [gha_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                             errors,
    output int                             pending
);
    import gha_pkg::*;

    // Declared so that new_index lands in the lowest bits, as on m_tdata.
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   alive;
        logic [GEN_BITS-1:0]    generation;
        logic [INDEX_BITS-1:0]  index;
    } result_t;

    logic [GEN_BITS-1:0]   gen_table [SLOTS];
    logic [INDEX_BITS-1:0] free_slots [SLOTS];
    logic [CNT_BITS-1:0]   stack_depth;
    logic [CNT_BITS-1:0]   high_water;
    result_t               due_results [$];
    result_t               got;
    result_t               want;
    int                    result_num;

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        $display("ERROR at %0t, result %0d: %s expected %0d, got %0d",
                 $time, result_num, what, want_v, got_v);
        errors++;
    endtask

    // Slots at or above the high-water mark were never handed out and count as dead.
    function automatic logic slot_live(logic [INDEX_BITS-1:0] idx, logic [GEN_BITS-1:0] gen);
        return ({1'b0, idx} < high_water) && (gen_table[idx] == gen);
    endfunction

    function automatic result_t apply_handle_op(logic [FUNC_BITS-1:0] fn,
                                                logic [INDEX_BITS-1:0] idx,
                                                logic [GEN_BITS-1:0] gen);
        result_t r;
        r = '0;
        case (fn)
            FN_CREATE:
            begin
                if (stack_depth != '0)
                begin
                    stack_depth  = stack_depth - CNT_BITS'(1);
                    r.index      = free_slots[stack_depth[INDEX_BITS-1:0]];
                    r.generation = gen_table[r.index];
                end
                else if (high_water != SLOTS_CNT)
                begin
                    r.index            = high_water[INDEX_BITS-1:0];
                    gen_table[r.index] = '0;
                    high_water         = high_water + CNT_BITS'(1);
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
            FN_QUERY:
            begin
                r.alive = slot_live(idx, gen);
            end
            FN_DESTROY:
            begin
                if (!slot_live(idx, gen))
                begin
                    r.status = ST_DEAD;
                end
                else
                begin
                    gen_table[idx] = gen_table[idx] + GEN_BITS'(1);
                    // A full stack drops the push but the generation still moves on.
                    if (stack_depth != SLOTS_CNT)
                    begin
                        free_slots[stack_depth[INDEX_BITS-1:0]] = idx;
                        stack_depth = stack_depth + CNT_BITS'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                gen_table[i] = '0;
            end
            stack_depth = '0;
            high_water  = '0;
            result_num  = 0;
            due_results.delete();
            pending = 0;
        end
        else
        begin
            // Results leave only after their request has been captured and executed, so check them first.
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[OUT_FIELDS_W-1:0];
                if (due_results.size() == 0)
                begin
                    report_mismatch("result with nothing outstanding, raw", 0, int'(got));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.index != want.index)
                        report_mismatch("new_index", int'(want.index), int'(got.index));
                    if (got.generation != want.generation)
                        report_mismatch("new_generation", int'(want.generation),
                                        int'(got.generation));
                    if (got.alive != want.alive)
                        report_mismatch("is_alive", int'(want.alive), int'(got.alive));
                    if (got.status != want.status)
                        report_mismatch("status", int'(want.status), int'(got.status));
                end
                result_num++;
            end
            if (s_tvalid && s_tready)
            begin
                due_results.push_back(apply_handle_op(s_tdata[IN_FUNC_LSB +: FUNC_BITS],
                                                      s_tdata[IN_IDX_LSB +: INDEX_BITS],
                                                      s_tdata[IN_GEN_LSB +: GEN_BITS]));
            end
            pending = due_results.size();
        end
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the generational handle allocator: stimulus, flow control and verdict.
module tb;
    import gha_pkg::*;

    // The one func code the block ignores; it still answers with an all-zero result.
    localparam logic [FUNC_BITS-1:0] FN_UNUSED = 2'd3;

    // Result field positions on m_tdata, lowest bit up.
    localparam int R_GEN_LSB    = INDEX_BITS;
    localparam int R_STATUS_LSB = INDEX_BITS + GEN_BITS + 1;

    // Cycles without any transfer before the run is declared hung. The longest
    // legal quiet stretch is the receiver hold-off below, well under this.
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AT_RESULT = 400;

    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        logic [GEN_BITS-1:0]   gen;
    } handle_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;

    // Stimulus bookkeeping. Handles handed out by the block are collected from
    // the results so that most destroys and queries use real handles.
    handle_t              live_handles [$];
    handle_t              retired [$];
    logic [FUNC_BITS-1:0] issued_funcs [$];
    int                   tx_count;
    int                   rx_count;
    int                   idle_cycles;
    bit                   tx_burst;
    bit                   rx_burst;
    bit                   seen_full;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    generational_handle_allocator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    gha_checker monitor (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (mismatches),
        .pending  (outstanding)
    );

    // Watchdog: any transfer on either side counts as progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("generational_handle_allocator test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one request and returns at the edge where it is transferred. The
    // valid line is left high, so a follow-on request with no gap simply
    // replaces the data in the same step.
    task automatic send_request(input logic [FUNC_BITS-1:0] fn,
                                input logic [INDEX_BITS-1:0] idx,
                                input logic [GEN_BITS-1:0] gen);
        int                   gap;
        logic [IN_DATA_W-1:0] word;
        gap  = tx_burst ? 0 : $urandom_range(0, 4);
        word = '0;
        word[IN_FUNC_LSB +: FUNC_BITS] = fn;
        word[IN_IDX_LSB +: INDEX_BITS] = idx;
        word[IN_GEN_LSB +: GEN_BITS]   = gen;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        issued_funcs.push_back(fn);
        tx_count++;
    endtask

    // Drops valid and waits until every request sent so far has its result back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (rx_count != tx_count)
        begin
            @(posedge clk);
        end
    endtask

    // Mixed traffic: mostly creates and destroys of real handles, with queries,
    // stale and random handles, and the ignored func code mixed in.
    task automatic random_mix(input int count);
        int      pick;
        int      j;
        handle_t h;
        for (int n = 0; n < count; n++)
        begin
            // Every hundred requests, maybe switch either side to back-to-back transfers.
            if (n % 100 == 0)
            begin
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 35 || (pick < 78 && live_handles.size() == 0))
            begin
                send_request(FN_CREATE, INDEX_BITS'($urandom_range(0, 1023)),
                             GEN_BITS'($urandom_range(0, 255)));
            end
            else if (pick < 60)
            begin
                j = $urandom_range(0, live_handles.size() - 1);
                h = live_handles[j];
                live_handles.delete(j);
                retired.push_back(h);
                if (retired.size() > 32)
                    void'(retired.pop_front());
                send_request(FN_DESTROY, h.idx, h.gen);
            end
            else if (pick < 78)
            begin
                h = live_handles[$urandom_range(0, live_handles.size() - 1)];
                send_request(FN_QUERY, h.idx, h.gen);
            end
            else if (pick < 88 && retired.size() > 0)
            begin
                // Old handles: dead with their own generation, but alive again with
                // the next one while the slot sits freed.
                h = retired[$urandom_range(0, retired.size() - 1)];
                h.gen = h.gen + GEN_BITS'($urandom_range(0, 1));
                send_request($urandom_range(0, 1) ? FN_DESTROY : FN_QUERY, h.idx, h.gen);
            end
            else if (pick < 96)
            begin
                send_request($urandom_range(0, 1) ? FN_DESTROY : FN_QUERY,
                             INDEX_BITS'($urandom_range(0, 1023)),
                             GEN_BITS'($urandom_range(0, 255)));
            end
            else
            begin
                send_request(FN_UNUSED, INDEX_BITS'($urandom_range(0, 1023)),
                             GEN_BITS'($urandom_range(0, 255)));
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // Destroys one handle over and over with its slot's current generation, so
    // the generation wraps around and the same slot piles up on the free stack.
    task automatic spin_generation();
        handle_t h;
        if (live_handles.size() > 0)
        begin
            h = live_handles.pop_back();
            for (int k = 0; k < 260; k++)
            begin
                send_request(FN_DESTROY, h.idx, h.gen);
                h.gen = h.gen + GEN_BITS'(1);
            end
        end
    endtask

    // Creates until the block reports that no slot is left. The result arrives
    // a few requests late, so a handful of extra creates also see the full case.
    task automatic fill_slots();
        int n;
        n = 0;
        seen_full = 1'b0;
        while (!seen_full && n < 2200)
        begin
            send_request(FN_CREATE, INDEX_BITS'($urandom_range(0, 1023)),
                         GEN_BITS'($urandom_range(0, 255)));
            n++;
        end
    endtask

    // Receiver: draws a stall before each result and, once, holds off long
    // enough for the block to back up and stall its input.
    initial
    begin
        int                   stall;
        bit                   held_off;
        logic [FUNC_BITS-1:0] fn;
        logic [STATUS_BITS-1:0] st;
        held_off = 1'b0;
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            stall = rx_burst ? 0 : $urandom_range(0, 4);
            if (!held_off && rx_count >= HOLD_AT_RESULT)
            begin
                held_off = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                @(posedge clk);
            end
            rx_count++;
            fn = (issued_funcs.size() > 0) ? issued_funcs.pop_front() : FN_QUERY;
            st = m_tdata[R_STATUS_LSB +: STATUS_BITS];
            if (fn == FN_CREATE && st == ST_OK)
            begin
                live_handles.push_back('{idx: m_tdata[INDEX_BITS-1:0],
                                         gen: m_tdata[R_GEN_LSB +: GEN_BITS]});
            end
            else if (fn == FN_CREATE && st == ST_FULL)
            begin
                seen_full = 1'b1;
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        tx_count    = 0;
        rx_count    = 0;
        idle_cycles = 0;
        tx_burst    = 1'b0;
        rx_burst    = 1'b0;
        seen_full   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Slots that were never handed out are dead to both query
        // and destroy, at either end of the field ranges.
        send_request(FN_QUERY, 10'd0, 8'd0);
        send_request(FN_DESTROY, 10'd1023, 8'd255);
        send_request(FN_CREATE, 10'd0, 8'd0);
        send_request(FN_CREATE, 10'd1023, 8'd255);
        send_request(FN_QUERY, 10'd0, 8'd0);
        send_request(FN_QUERY, 10'd0, 8'd255);
        send_request(FN_DESTROY, 10'd0, 8'd0);
        // A freed slot with its current generation still reads as alive, and a
        // destroy of it pushes the slot a second time.
        send_request(FN_QUERY, 10'd0, 8'd1);
        send_request(FN_DESTROY, 10'd0, 8'd1);
        send_request(FN_DESTROY, 10'd0, 8'd0);
        // Both pushes of slot 0 come back, then a never-used slot.
        send_request(FN_CREATE, 10'd0, 8'd0);
        send_request(FN_CREATE, 10'd0, 8'd0);
        send_request(FN_CREATE, 10'd0, 8'd0);
        // The ignored func code, with all-ones and all-zero handle fields.
        send_request(FN_UNUSED, 10'd1023, 8'd255);
        send_request(FN_UNUSED, 10'd0, 8'd0);
        send_request(FN_QUERY, 10'd1023, 8'd0);
        send_request(FN_DESTROY, 10'd1, 8'd0);
        send_request(FN_CREATE, 10'd0, 8'd0);
        send_request(FN_QUERY, 10'd2, 8'd0);
        send_request(FN_DESTROY, 10'd2, 8'd255);

        // Random part, then every slot handed out and one slot's generation
        // wrapped; the long receiver hold-off falls inside the fill.
        random_mix(100);
        fill_slots();
        spin_generation();

        wait_for_results();
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("generational_handle_allocator test passed");
        end
        else
        begin
            $display("generational_handle_allocator test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/gha_pkg.sv
sv/gha_ram.sv
sv/gha_ctrl.sv
sv/gha_dp.sv
sv/generational_handle_allocator.sv
verif/gha_checker.sv
verif/tb.sv
